>>> sv/ctok_pkg.sv
// Package: token kinds, byte classes, widths and lookup functions for the C tokenizer.
package ctok_pkg;

  localparam int unsigned LengthBits = 16;
  localparam int unsigned LineBits   = 20;
  localparam int unsigned ColumnBits = 16;
  localparam int unsigned TabStop    = 8;
  localparam int unsigned TabShift   = $clog2(TabStop);

  localparam logic [LengthBits-1:0] LenMax  = '1;
  localparam logic [LineBits-1:0]   LineMax = '1;
  localparam logic [ColumnBits-1:0] ColMax  = '1;

  typedef enum logic [1:0] {
    REQ_BYTE = 2'd0,
    REQ_EOI  = 2'd1
  } req_e;

  // byte class bits
  localparam logic [6:0] ClId  = 7'h01;
  localparam logic [6:0] ClDig = 7'h02;
  localparam logic [6:0] ClHex = 7'h04;
  localparam logic [6:0] ClExp = 7'h08;
  localparam logic [6:0] ClDot = 7'h10;
  localparam logic [6:0] ClHws = 7'h20;
  localparam logic [6:0] ClVws = 7'h40;

  typedef enum logic [5:0] {
    KD_EMPTY = 6'd0, KD_SPACE = 6'd1, KD_IDENT = 6'd2, KD_INT = 6'd3, KD_FLOAT = 6'd4,
    KD_CHAR = 6'd5, KD_STR = 6'd6, KD_DOT = 6'd7, KD_DOT2 = 6'd8, KD_COMMENT = 6'd9,
    KD_NOT = 6'd10, KD_NE = 6'd11, KD_MOD = 6'd12, KD_MOD_EQ = 6'd13, KD_STAR = 6'd14,
    KD_MUL_EQ = 6'd15, KD_SHL = 6'd16, KD_SHL_EQ = 6'd17, KD_SAR = 6'd18,
    KD_SAR_EQ = 6'd19, KD_HASH = 6'd20, KD_HASH2 = 6'd21, KD_COLON = 6'd22,
    KD_COLON2 = 6'd23, KD_SET = 6'd24, KD_EQEQ = 6'd25, KD_XOR = 6'd26,
    KD_XOR_EQ = 6'd27, KD_DOT3 = 6'd28, KD_LT = 6'd29, KD_LE = 6'd30, KD_GT = 6'd31,
    KD_GE = 6'd32, KD_AMP = 6'd33, KD_LAND = 6'd34, KD_AND_EQ = 6'd35, KD_BOR = 6'd36,
    KD_LOR = 6'd37, KD_OR_EQ = 6'd38, KD_PLUS = 6'd39, KD_INC = 6'd40,
    KD_ADD_EQ = 6'd41, KD_MINUS = 6'd42, KD_DEC = 6'd43, KD_ARROW = 6'd44,
    KD_SUB_EQ = 6'd45, KD_SLASH = 6'd46, KD_DIV_EQ = 6'd47, KD_TILDE = 6'd48,
    KD_BSLASH = 6'd49, KD_SEMI = 6'd50, KD_COMMA = 6'd51, KD_LPAR = 6'd52,
    KD_RPAR = 6'd53, KD_LBRK = 6'd54, KD_RBRK = 6'd55, KD_LBRC = 6'd56,
    KD_RBRC = 6'd57, KD_QUEST = 6'd58, KD_BAD_CHAR = 6'd59, KD_BAD_STR = 6'd60,
    KD_BAD_CHR = 6'd61, KD_BAD_CMT = 6'd62, KD_UNUSED = 6'd63
  } kind_e;

  typedef struct packed {
    logic [5:0]            kind;
    logic [LengthBits-1:0] length;
    logic [LineBits-1:0]   line;
    logic [ColumnBits-1:0] column;
    logic                  last;
  } tok_t;

  function automatic logic [6:0] byte_class(input logic [7:0] c);
    logic [6:0] cl;
    cl = '0;
    if (c >= 8'd128) cl = ClId;
    else if (c >= "0" && c <= "9") cl = ClDig | ClHex;
    else if (c == "E" || c == "e") cl = ClId | ClHex | ClExp;
    else if (c == "P" || c == "p") cl = ClId | ClExp;
    else if ((c >= "A" && c <= "F") || (c >= "a" && c <= "f") || c == "x" || c == "X")
      cl = ClId | ClHex;
    else if ((c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == "_") cl = ClId;
    else if (c == ".") cl = ClDot;
    else if (c == 8'd10) cl = ClVws;
    else if (c == 8'd9 || c == 8'd11 || c == 8'd12 || c == 8'd13 || c == 8'd32) cl = ClHws;
    return cl;
  endfunction

  function automatic kind_e start_kind(input logic [7:0] c);
    logic [6:0] cl;
    kind_e k;
    cl = byte_class(c);
    if ((cl & ClDig) != '0) k = KD_INT;
    else if ((cl & (ClHws | ClVws)) != '0) k = KD_SPACE;
    else begin
      case (c)
        "<": k = KD_LT;      ">": k = KD_GT;     "=": k = KD_SET;   "!": k = KD_NOT;
        "+": k = KD_PLUS;    "-": k = KD_MINUS;  "*": k = KD_STAR;  "%": k = KD_MOD;
        "/": k = KD_SLASH;   "&": k = KD_AMP;    "|": k = KD_BOR;   "^": k = KD_XOR;
        "~": k = KD_TILDE;   ".": k = KD_DOT;    ":": k = KD_COLON; "\\": k = KD_BSLASH;
        ";": k = KD_SEMI;    ",": k = KD_COMMA;  "(": k = KD_LPAR;  ")": k = KD_RPAR;
        "[": k = KD_LBRK;    "]": k = KD_RBRK;   "{": k = KD_LBRC;  "}": k = KD_RBRC;
        "?": k = KD_QUEST;   "\"": k = KD_STR;   "'": k = KD_CHAR;  "#": k = KD_HASH;
        default: k = ((cl & ClId) != '0) ? KD_IDENT : KD_EMPTY;
      endcase
    end
    return k;
  endfunction

endpackage

>>> sv/ctok_stream_if.sv
// Interfaces: valid/ready channels for input beats, result beats and config writes.
interface ctok_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] src_byte;
  modport source (output valid, req_type, src_byte, input ready);
  modport sink (input valid, req_type, src_byte, output ready);
endinterface

interface ctok_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  tok_kind;
  logic [15:0] tok_length;
  logic [19:0] start_line;
  logic [15:0] start_column;
  logic        last_of_run;
  modport source (output valid, tok_kind, tok_length, start_line, start_column,
                  last_of_run, input ready);
  modport sink (input valid, tok_kind, tok_length, start_line, start_column,
                last_of_run, output ready);
endinterface

interface ctok_cfg_if;
  logic valid;
  logic ready;
  logic skip_blank;
  modport source (output valid, skip_blank, input ready);
  modport sink (input valid, skip_blank, output ready);
endinterface

>>> sv/c_language_tokenizer.sv
// Top level: C tokenizer with input stage, lexer core and four-entry result queue.
// One input beat (a source byte or an end-of-input marker) is taken per clock
// whenever the result queue has room for the up to two results that the beat can
// cause; a beat is registered, lexed by combinational logic and its results land in
// a four-entry output queue, so sustained throughput is one beat per cycle while the
// consumer drains at least as fast as tokens appear. From input to the first result a
// beat passes the input register and the queue register. A beat that yields two results
// (a closed token plus a new one's error, or a flushed token plus the end marker)
// fills two queue entries; input stalls only while the queue, counting the results
// the lexer writes this cycle, would hold more than two. Config writes
// (skip_blank) are accepted at any time and should be made only while idle.
module c_language_tokenizer
  import ctok_pkg::*;
(
  input logic     clk_i,
  input logic     rst_ni,
  ctok_in_if.sink   in_if,
  ctok_cfg_if.sink  cfg_if,
  ctok_out_if.source out_if
);

  logic       skip_q;
  // input stage
  logic       iv_q;
  logic       ieoi_q;
  logic [7:0] ibyte_q;
  // result queue
  tok_t       q_q [4];
  logic [1:0] rd_q, wr_q;
  logic [2:0] cnt_q;

  tok_t       t0, t1;
  logic [1:0] n;
  logic       pop, take;

  // room check counts the results the lexer writes this cycle
  assign take         = in_if.valid && in_if.ready;
  assign in_if.ready  = (cnt_q + {1'b0, n}) <= 3'd2;
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) skip_q <= 1'b0;
    else if (cfg_if.valid) skip_q <= cfg_if.skip_blank;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) iv_q <= 1'b0;
    else iv_q <= take;
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      ieoi_q  <= in_if.req_type;
      ibyte_q <= in_if.src_byte;
    end
  end

  ctok_lexer u_lexer (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (iv_q),
    .eoi_i   (ieoi_q),
    .byte_i  (ibyte_q),
    .skip_i  (skip_q),
    .tok0_o  (t0),
    .tok1_o  (t1),
    .count_o (n)
  );

  assign pop = out_if.valid && out_if.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q <= '0; wr_q <= '0; cnt_q <= '0;
    end else begin
      rd_q  <= rd_q + {1'b0, pop};
      wr_q  <= wr_q + n;
      cnt_q <= cnt_q + {1'b0, n} - {2'b0, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (n != 2'd0) q_q[wr_q] <= t0;
    if (n == 2'd2) q_q[wr_q + 2'd1] <= t1;
  end

  assign out_if.valid        = cnt_q != 3'd0;
  assign out_if.tok_kind     = q_q[rd_q].kind;
  assign out_if.tok_length   = q_q[rd_q].length;
  assign out_if.start_line   = q_q[rd_q].line;
  assign out_if.start_column = q_q[rd_q].column;
  assign out_if.last_of_run  = q_q[rd_q].last;

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'd4) else $error("result queue overflow");
  a_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    iv_q |-> cnt_q <= 3'd2) else $error("no room for lexer results");
  a_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> iv_q) else $error("accepted beat lost");

endmodule

>>> sv/ctok_lexer.sv
// Lexer core: per-byte token state update producing up to two result beats.
module ctok_lexer
  import ctok_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic       eoi_i,
  input  logic [7:0] byte_i,
  input  logic       skip_i,
  output tok_t       tok0_o,
  output tok_t       tok1_o,
  output logic [1:0] count_o
);

  kind_e                 kind_q, kind_d;
  logic [LengthBits-1:0] len_q, len_d;
  logic [LineBits-1:0]   oline_q, oline_d, line_q, line_d;
  logic [ColumnBits-1:0] ocol_q, ocol_d, col_q, col_d;
  logic                  esc_q, esc_d, lcmt_q, lcmt_d, halt_q, halt_d;
  logic [7:0]            prev_q, prev_d;

  logic [6:0] cl;
  kind_e      ext_kind, new_kind;
  logic [1:0] act; // 0 close without byte, 1 absorb, 2 absorb and close
  logic       ext_lcmt, ext_esc;
  logic [ColumnBits:0] tab_col;

  tok_t       res [2];
  logic [1:0] n;

  always_comb begin
    cl       = byte_class(byte_i);
    ext_kind = kind_q;
    ext_lcmt = lcmt_q;
    ext_esc  = esc_q;
    act      = 2'd0;
    case (kind_q)
      KD_SPACE: act = ((cl & (ClHws | ClVws)) != '0) ? 2'd1 : 2'd0;
      KD_IDENT: act = ((cl & (ClId | ClDig)) != '0) ? 2'd1 : 2'd0;
      KD_INT: begin
        if ((cl & ClDot) != '0) begin
          ext_kind = KD_FLOAT;
          act = 2'd1;
        end else act = ((cl & (ClDig | ClHex)) != '0) ? 2'd1 : 2'd0;
      end
      KD_FLOAT: begin
        if ((cl & (ClDig | ClExp)) != '0) act = 2'd1;
        else if ((byte_i == "+" || byte_i == "-") && (byte_class(prev_q) & ClExp) != '0)
          act = 2'd1;
      end
      KD_CHAR, KD_STR: begin
        if (esc_q) begin
          ext_esc = 1'b0;
          act = 2'd1;
        end else if (byte_i == "\\") begin
          ext_esc = 1'b1;
          act = 2'd1;
        end else if (byte_i != ((kind_q == KD_CHAR) ? 8'h27 : 8'h22)) act = 2'd1;
        else act = 2'd2;
      end
      KD_DOT: begin
        if ((cl & ClDig) != '0) begin
          ext_kind = KD_FLOAT;
          act = 2'd1;
        end else if ((cl & ClDot) != '0) begin
          ext_kind = KD_DOT2;
          act = 2'd1;
        end
      end
      KD_COMMENT: begin
        if (lcmt_q) act = ((cl & ClVws) != '0) ? 2'd2 : 2'd1;
        else act = (prev_q == "*" && byte_i == "/") ? 2'd2 : 2'd1;
      end
      KD_NOT:   if (byte_i == "=") begin ext_kind = KD_NE;     act = 2'd1; end
      KD_MOD:   if (byte_i == "=") begin ext_kind = KD_MOD_EQ; act = 2'd1; end
      KD_STAR:  if (byte_i == "=") begin ext_kind = KD_MUL_EQ; act = 2'd1; end
      KD_SHL:   if (byte_i == "=") begin ext_kind = KD_SHL_EQ; act = 2'd1; end
      KD_SAR:   if (byte_i == "=") begin ext_kind = KD_SAR_EQ; act = 2'd1; end
      KD_HASH:  if (byte_i == "#") begin ext_kind = KD_HASH2;  act = 2'd1; end
      KD_COLON: if (byte_i == ":") begin ext_kind = KD_COLON2; act = 2'd1; end
      KD_SET:   if (byte_i == "=") begin ext_kind = KD_EQEQ;   act = 2'd1; end
      KD_XOR:   if (byte_i == "=") begin ext_kind = KD_XOR_EQ; act = 2'd1; end
      KD_DOT2:  if (byte_i == ".") begin ext_kind = KD_DOT3;   act = 2'd1; end
      KD_LT: begin
        if (byte_i == "<") begin ext_kind = KD_SHL; act = 2'd1; end
        else if (byte_i == "=") begin ext_kind = KD_LE; act = 2'd1; end
      end
      KD_GT: begin
        if (byte_i == ">") begin ext_kind = KD_SAR; act = 2'd1; end
        else if (byte_i == "=") begin ext_kind = KD_GE; act = 2'd1; end
      end
      KD_AMP: begin
        if (byte_i == "&") begin ext_kind = KD_LAND; act = 2'd1; end
        else if (byte_i == "=") begin ext_kind = KD_AND_EQ; act = 2'd1; end
      end
      KD_BOR: begin
        if (byte_i == "|") begin ext_kind = KD_LOR; act = 2'd1; end
        else if (byte_i == "=") begin ext_kind = KD_OR_EQ; act = 2'd1; end
      end
      KD_PLUS: begin
        if (byte_i == "+") begin ext_kind = KD_INC; act = 2'd1; end
        else if (byte_i == "=") begin ext_kind = KD_ADD_EQ; act = 2'd1; end
      end
      KD_MINUS: begin
        if (byte_i == "-") begin ext_kind = KD_DEC; act = 2'd1; end
        else if (byte_i == ">") begin ext_kind = KD_ARROW; act = 2'd1; end
        else if (byte_i == "=") begin ext_kind = KD_SUB_EQ; act = 2'd1; end
      end
      KD_SLASH: begin
        if (byte_i == "/" || byte_i == "*") begin
          ext_kind = KD_COMMENT;
          ext_lcmt = (byte_i == "/");
          act = 2'd1;
        end else if (byte_i == "=") begin
          ext_kind = KD_DIV_EQ;
          act = 2'd1;
        end
      end
      default: act = 2'd0;
    endcase
  end

  // next column after a tab: round down to a stop, then one stop further
  assign tab_col = {1'b0, (((col_q - 1'b1) >> TabShift) << TabShift)} + (ColumnBits + 1)'(1)
                   + (ColumnBits + 1)'(TabStop);

  always_comb begin
    logic                  open_now, take_now, suppress;
    logic [LengthBits-1:0] len_base;
    tok_t                  t;
    kind_d = kind_q; len_d = len_q; oline_d = oline_q; ocol_d = ocol_q;
    line_d = line_q; col_d = col_q; esc_d = esc_q; lcmt_d = lcmt_q;
    halt_d = halt_q; prev_d = prev_q;
    new_kind = start_kind(byte_i);
    res[0] = '0; res[1] = '0; n = 2'd0;
    open_now = 1'b0; take_now = 1'b0; len_base = len_q;
    t = '0;
    suppress = 1'b0;
    if (step_i && eoi_i) begin
      if (kind_q != KD_EMPTY) begin
        t.kind = kind_q;
        if (kind_q == KD_STR) t.kind = KD_BAD_STR;
        else if (kind_q == KD_CHAR) t.kind = KD_BAD_CHR;
        else if (kind_q == KD_COMMENT && !lcmt_q) t.kind = KD_BAD_CMT;
        t.length = len_q; t.line = oline_q; t.column = ocol_q;
        // an unterminated block comment is an error and always shows
        suppress = skip_i && (t.kind == KD_COMMENT || t.kind == KD_SPACE);
        if (!suppress) begin res[0] = t; n = 2'd1; end
      end
      t = '0; t.line = line_q; t.column = col_q;
      res[n[0]] = t; n = n + 2'd1;
      kind_d = KD_EMPTY; len_d = '0; oline_d = LineBits'(1); ocol_d = ColumnBits'(1);
      line_d = LineBits'(1); col_d = ColumnBits'(1); esc_d = 1'b0; prev_d = '0;
      lcmt_d = 1'b0; halt_d = 1'b0;
    end else if (step_i && !halt_q) begin
      if (kind_q == KD_EMPTY) open_now = 1'b1;
      else if (act == 2'd0) begin
        t.kind = kind_q; t.length = len_q; t.line = oline_q; t.column = ocol_q;
        suppress = skip_i && (kind_q == KD_COMMENT || kind_q == KD_SPACE);
        if (!suppress) begin res[0] = t; n = 2'd1; end
        open_now = 1'b1;
      end else begin
        take_now = 1'b1;
        kind_d = ext_kind; esc_d = ext_esc; lcmt_d = ext_lcmt;
        if (act == 2'd2) begin
          t.kind = ext_kind;
          t.length = (len_q != LenMax) ? len_q + 1'b1 : len_q;
          t.line = oline_q; t.column = ocol_q;
          suppress = skip_i && ext_kind == KD_COMMENT;
          if (!suppress) begin res[0] = t; n = 2'd1; end
          kind_d = KD_EMPTY;
        end
      end
      if (open_now) begin
        oline_d = line_q; ocol_d = col_q; esc_d = 1'b0; lcmt_d = 1'b0;
        len_base = '0;
        if (new_kind == KD_EMPTY) begin
          t = '0; t.kind = KD_BAD_CHAR; t.line = line_q; t.column = col_q;
          res[n[0]] = t; n = n + 2'd1;
          kind_d = KD_EMPTY; halt_d = 1'b1; len_d = '0;
        end else begin
          kind_d = new_kind; take_now = 1'b1;
        end
      end
      if (take_now) begin
        len_d = (len_base != LenMax) ? len_base + 1'b1 : len_base;
        prev_d = byte_i;
        if (byte_i == 8'd10) begin
          line_d = (line_q != LineMax) ? line_q + 1'b1 : line_q;
          col_d = ColumnBits'(1);
        end else if (byte_i == 8'd9) begin
          col_d = tab_col[ColumnBits] ? ColMax : tab_col[ColumnBits-1:0];
        end else if (col_q != ColMax) col_d = col_q + 1'b1;
      end
    end
    if (n == 2'd2) res[1].last = 1'b1;
    else if (n == 2'd1) res[0].last = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= KD_EMPTY; len_q <= '0; oline_q <= LineBits'(1); ocol_q <= ColumnBits'(1);
      line_q <= LineBits'(1); col_q <= ColumnBits'(1); esc_q <= 1'b0; prev_q <= '0;
      lcmt_q <= 1'b0; halt_q <= 1'b0;
    end else begin
      kind_q <= kind_d; len_q <= len_d; oline_q <= oline_d; ocol_q <= ocol_d;
      line_q <= line_d; col_q <= col_d; esc_q <= esc_d; prev_q <= prev_d;
      lcmt_q <= lcmt_d; halt_q <= halt_d;
    end
  end

  assign tok0_o  = res[0];
  assign tok1_o  = res[1];
  assign count_o = n;

  a_halt_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halt_q && step_i && !eoi_i |-> count_o == 2'd0) else $error("output while halted");
  a_eoi_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && eoi_i |=> kind_q == KD_EMPTY && !halt_q) else $error("eoi did not clear");
  a_halt_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halt_q |-> kind_q == KD_EMPTY) else $error("open token while halted");

endmodule
